// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the quaternion unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define QMR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("qmr assertion failed");

// Checked on every rising edge, reset included.
`define QMR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qmr assertion failed");

`endif

// ----- rtl/qmr_pkg.sv -----
// Shared constants for the quaternion multiply/rotate unit.
// No dependencies; used by qmr_sum_stage and the top level.
package qmr_pkg;

    localparam int COMP_WIDTH_DEF = 16;

    // Hamilton product sign table: component c takes p[i]*q[c^i],
    // subtracted where bit i of row c is set.
    localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

// ----- rtl/qmr_prod_stage.sv -----
// Product stage: all sixteen cross products of two quaternions, registered.
// Standalone; instantiated twice by quaternion_multiply_rotate_unit.
module qmr_prod_stage #(
    parameter int PW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [PW-1:0]       in_p [4],
    input  logic signed [QW-1:0]       in_q [4],
    input  logic        [SW-1:0]       in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [PW+QW-1:0]    out_prod [4][4],
    output logic        [SW-1:0]       out_side
);

    logic                    valid_reg;
    logic signed [PW+QW-1:0] prod_reg [4][4];
    logic        [SW-1:0]    side_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= in_p[i] * in_q[j];
                end
            end
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/qmr_sum_stage.sv -----
// Round, sum and saturate stage of one Hamilton product, registered.
// Depends on qmr_pkg (sign table).
module qmr_sum_stage import qmr_pkg::*; #(
    parameter int W   = COMP_WIDTH_DEF,
    parameter int PRW = 2 * COMP_WIDTH_DEF,
    parameter int SW  = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [PRW-1:0]  in_prod [4][4],
    input  logic        [SW-1:0]   in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [W-1:0]    out_r [4],
    output logic        [SW-1:0]   out_side
);

    localparam int F    = W - 2;
    localparam int RW   = PRW + 1 - F;
    localparam int SUMW = RW + 2;
    localparam logic signed [PRW:0] HALF = (PRW + 1)'(1) << (F - 1);

    logic signed [PRW:0]    ext   [4][4];
    logic signed [RW-1:0]   rnd   [4][4];
    logic signed [SUMW-1:0] sum   [4];
    logic signed [W-1:0]    r_next [4];

    logic                   valid_reg;
    logic signed [W-1:0]    r_reg [4];
    logic        [SW-1:0]   side_reg;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum[c] = '0;
            for (int i = 0; i < 4; i++) begin
                ext[c][i] = {in_prod[i][2'(c ^ i)][PRW-1], in_prod[i][2'(c ^ i)]} + HALF;
                rnd[c][i] = ext[c][i][PRW:F];
                if (HAM_NEG[c][i]) begin
                    sum[c] = sum[c] - SUMW'(rnd[c][i]);
                end else begin
                    sum[c] = sum[c] + SUMW'(rnd[c][i]);
                end
            end
            if (sum[c][SUMW-1:W-1] == '0 || sum[c][SUMW-1:W-1] == '1) begin
                r_next[c] = sum[c][W-1:0];
            end else if (sum[c][SUMW-1]) begin
                r_next[c] = {1'b1, {(W-1){1'b0}}};
            end else begin
                r_next[c] = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/quaternion_multiply_rotate_unit.sv -----
// Quaternion multiply / vector rotate unit, top level.
// Four registers from request accept to m_tvalid: two passes of product and
// round-sum stages. Throughput: one request per cycle unless m_tready stalls the output.
// Reset (aresetn low, synchronous) empties all stages; m_tvalid goes low.
// Depends on qmr_pkg, qmr_prod_stage, qmr_sum_stage, assert_macros.svh.
`include "assert_macros.svh"

module quaternion_multiply_rotate_unit import qmr_pkg::*; #(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [8*COMP_WIDTH-1:0]               s_tdata,
    // mode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // r_w, r_x, r_y, r_z, zero pad
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0]     m_tdata
);

    localparam int W      = COMP_WIDTH;
    localparam int OUT_TW = ((4 * W + 7) / 8) * 8;
    localparam int SW1    = 4 * W + 1;

    logic signed [W-1:0]     a_in  [4];
    logic signed [W-1:0]     q1    [4];
    logic        [SW1-1:0]   side1;

    logic                    p1_valid, p1_ready;
    logic signed [2*W-1:0]   p1_prod [4][4];
    logic        [SW1-1:0]   p1_side;

    logic                    s1_valid, s1_ready;
    logic signed [W-1:0]     t_q   [4];
    logic        [SW1-1:0]   s1_side;

    logic signed [W:0]       q2    [4];
    logic signed [W:0]       one_q;
    logic                    s1_mode;

    logic                    p2_valid, p2_ready;
    logic signed [2*W:0]     p2_prod [4][4];
    logic        [0:0]       p2_side;

    logic signed [W-1:0]     r_q   [4];

    assign one_q   = {{2{1'b0}}, 1'b1, {(W-2){1'b0}}};
    assign s1_mode = s1_side[4*W];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a_in[i] = s_tdata[i*W +: W];
            q1[i]   = s_tdata[(4+i)*W +: W];
        end
        if (s_tuser) begin
            q1[0] = '0;
        end
        side1 = {s_tuser, s_tdata[4*W-1:0]};
    end

    // rotate: t * conj(a), negation at one extra bit; multiply: t * 1
    always_comb begin
        if (s1_mode) begin
            q2[0] = {s1_side[W-1], s1_side[W-1:0]};
            for (int i = 1; i < 4; i++) begin
                q2[i] = -{s1_side[i*W+W-1], s1_side[i*W +: W]};
            end
        end else begin
            q2[0] = one_q;
            for (int i = 1; i < 4; i++) begin
                q2[i] = '0;
            end
        end
    end

    qmr_prod_stage #(.PW(W), .QW(W), .SW(SW1)) u_prod1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_p      (a_in),
        .in_q      (q1),
        .in_side   (side1),
        .out_valid (p1_valid),
        .out_ready (p1_ready),
        .out_prod  (p1_prod),
        .out_side  (p1_side)
    );

    qmr_sum_stage #(.W(W), .PRW(2*W), .SW(SW1)) u_sum1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p1_valid),
        .in_ready  (p1_ready),
        .in_prod   (p1_prod),
        .in_side   (p1_side),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_r     (t_q),
        .out_side  (s1_side)
    );

    qmr_prod_stage #(.PW(W), .QW(W+1), .SW(1)) u_prod2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_p      (t_q),
        .in_q      (q2),
        .in_side   (s1_mode),
        .out_valid (p2_valid),
        .out_ready (p2_ready),
        .out_prod  (p2_prod),
        .out_side  (p2_side)
    );

    qmr_sum_stage #(.W(W), .PRW(2*W+1), .SW(1)) u_sum2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p2_valid),
        .in_ready  (p2_ready),
        .in_prod   (p2_prod),
        .in_side   (p2_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_r     (r_q),
        .out_side  ()
    );

    assign m_tdata = OUT_TW'({r_q[3], r_q[2], r_q[1], r_q[0]});

    `QMR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `QMR_ASSERT(a_full_when_blocked, aclk, aresetn, !s_tready |-> (p1_valid && s1_valid && p2_valid && m_tvalid && !m_tready))
    `QMR_ASSERT(a_bubble_fills, aclk, aresetn, (p2_valid && !m_tvalid) |=> m_tvalid)

endmodule

// ----- verif/qmr_tb_pkg.sv -----
// Shared types for the quaternion unit testbench: component, quaternion and mode.
// Depends on qmr_pkg for the component width; used by qmr_checker and tb.
package qmr_tb_pkg;

    typedef logic signed [qmr_pkg::COMP_WIDTH_DEF-1:0] comp_t;

    typedef struct packed {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
    } quat_t;

    typedef enum logic {
        MODE_MUL = 1'b0,
        MODE_ROT = 1'b1
    } qmode_e;

endpackage

// ----- verif/qmr_checker.sv -----
// Checker for the quaternion unit: watches both stream channels, predicts each
// result from the accepted request and compares it. Depends on qmr_pkg, qmr_tb_pkg.
module qmr_checker import qmr_pkg::*, qmr_tb_pkg::*; (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    input  logic                                          s_tready,
    input  logic [8*COMP_WIDTH_DEF-1:0]                   s_tdata,
    input  logic                                          s_tuser,
    input  logic                                          m_tvalid,
    input  logic                                          m_tready,
    input  logic [((4*COMP_WIDTH_DEF+7)/8)*8-1:0]         m_tdata,
    output int                                            errors,
    output int                                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W    = COMP_WIDTH_DEF;
    localparam int FRAC = W - 2;

    typedef struct packed {
        longint w;
        longint x;
        longint y;
        longint z;
    } qwide_t;

    quat_t expected_results[$];
    int    err_cnt = 0;

    function automatic longint round_prod(longint p, longint q);
        longint v;
        v = p * q + (longint'(1) << (FRAC - 1));
        return v >>> FRAC;
    endfunction

    function automatic longint clamp(longint v);
        longint hi;
        hi = (longint'(1) << (W - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic qwide_t hamilton(qwide_t p, qwide_t q);
        qwide_t r;
        r.w = clamp(round_prod(p.w, q.w) - round_prod(p.x, q.x)
                  - round_prod(p.y, q.y) - round_prod(p.z, q.z));
        r.x = clamp(round_prod(p.w, q.x) + round_prod(p.x, q.w)
                  + round_prod(p.y, q.z) - round_prod(p.z, q.y));
        r.y = clamp(round_prod(p.w, q.y) - round_prod(p.x, q.z)
                  + round_prod(p.y, q.w) + round_prod(p.z, q.x));
        r.z = clamp(round_prod(p.w, q.z) + round_prod(p.x, q.y)
                  - round_prod(p.y, q.x) + round_prod(p.z, q.w));
        return r;
    endfunction

    function automatic qwide_t widen(quat_t q);
        qwide_t r;
        r.w = longint'($signed(q.w));
        r.x = longint'($signed(q.x));
        r.y = longint'($signed(q.y));
        r.z = longint'($signed(q.z));
        return r;
    endfunction

    function automatic quat_t narrow(qwide_t q);
        quat_t r;
        r.w = comp_t'(q.w);
        r.x = comp_t'(q.x);
        r.y = comp_t'(q.y);
        r.z = comp_t'(q.z);
        return r;
    endfunction

    // Rotate: t = a*(0,v), r = t*conj(a); conj kept wide so -min does not wrap.
    function automatic quat_t quat_result(qmode_e md, quat_t a, quat_t b);
        qwide_t aw, bw, t, c;
        aw = widen(a);
        bw = widen(b);
        if (md == MODE_MUL)
            return narrow(hamilton(aw, bw));
        bw.w = 0;
        t    = hamilton(aw, bw);
        c.w  = aw.w;
        c.x  = -aw.x;
        c.y  = -aw.y;
        c.z  = -aw.z;
        return narrow(hamilton(t, c));
    endfunction

    function automatic quat_t quat_at(logic [8*W-1:0] bus, int base);
        quat_t q;
        q.w = bus[(base + 0)*W +: W];
        q.x = bus[(base + 1)*W +: W];
        q.y = bus[(base + 2)*W +: W];
        q.z = bus[(base + 3)*W +: W];
        return q;
    endfunction

    task automatic check_lane(string name, comp_t want, comp_t got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: r_%s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        quat_t got, want;
        if (!aresetn) begin
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(quat_result(qmode_e'(s_tuser),
                                           quat_at(s_tdata, 0), quat_at(s_tdata, 4)));
            if (m_tvalid && m_tready) begin
                got = quat_at({{(8*W - $bits(m_tdata)){1'b0}}, m_tdata}, 0);
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with no request pending, expected none got %h",
                             $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_lane("w", want.w, got.w);
                    check_lane("x", want.x, got.x);
                    check_lane("y", want.y, got.y);
                    check_lane("z", want.z, got.z);
                end
            end
        end
        pending <= expected_results.size();
        errors  <= err_cnt;
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for quaternion_multiply_rotate_unit: drives requests and output
// back-pressure, gives the verdict. Depends on qmr_pkg, qmr_tb_pkg, qmr_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qmr_pkg::*;
    import qmr_tb_pkg::*;

    localparam int W           = COMP_WIDTH_DEF;
    localparam int N_RAND      = 1950;
    localparam int IDLE_PCT    = 17;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN       = 12;
    localparam int HOLD_START  = 800;
    localparam int HOLD_LEN    = 300;

    localparam comp_t ONE  = comp_t'(1 << (W - 2));
    localparam comp_t MAXV = comp_t'((1 << (W - 1)) - 1);
    localparam comp_t MINV = comp_t'(1 << (W - 1));

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic [8*W-1:0]                     s_tdata  = '0;
    logic                               s_tuser  = 1'b0;
    logic                               m_tready = 1'b0;
    wire                                s_tready;
    wire                                m_tvalid;
    wire  [((4*W+7)/8)*8-1:0]           m_tdata;

    int errors;
    int pending;
    bit quiet_send = 1'b0;
    int n_mul      = 0;
    int n_rot      = 0;
    int stall_cyc  = 0;

    always #10 aclk = ~aclk;

    quaternion_multiply_rotate_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    qmr_checker u_chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    function automatic quat_t mk(comp_t w, comp_t x, comp_t y, comp_t z);
        quat_t q;
        q.w = w;
        q.x = x;
        q.y = y;
        q.z = z;
        return q;
    endfunction

    function automatic comp_t rnd_comp();
        int sel;
        int v;
        sel = $urandom_range(9);
        case (sel)
            0, 1: begin
                case ($urandom_range(5))
                    0: return MINV;
                    1: return MAXV;
                    2: return comp_t'(0);
                    3: return comp_t'(-1);
                    4: return ONE;
                    default: return -ONE;
                endcase
            end
            2, 3, 4, 5: return comp_t'($urandom);
            default: begin
                // magnitudes up to one (-ONE to ONE), the usual attitude range
                v = $urandom_range(2 * ONE);
                return comp_t'(v - ONE);
            end
        endcase
    endfunction

    function automatic quat_t rnd_quat();
        return mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
    endfunction

    task automatic push_req(qmode_e md, quat_t a, quat_t b);
        while (!quiet_send && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {b.z, b.y, b.x, b.w, a.z, a.y, a.x, a.w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (md == MODE_MUL) n_mul++;
        else n_rot++;
    endtask

    // output side: random back-pressure, one long hold, one stretch always ready
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (cyc >= 1500 && cyc < 2000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cyc <= 0;
        end else if (stall_cyc + 1 >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cyc <= stall_cyc + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_req(MODE_MUL, mk(0, 0, 0, 0), mk(0, 0, 0, 0));
        push_req(MODE_MUL, mk(ONE, 0, 0, 0), mk(1234, -2222, 3333, -4444));
        push_req(MODE_MUL, mk(MAXV, MAXV, MAXV, MAXV), mk(MAXV, MAXV, MAXV, MAXV));
        push_req(MODE_MUL, mk(MINV, MINV, MINV, MINV), mk(MINV, MINV, MINV, MINV));
        push_req(MODE_MUL, mk(MAXV, MAXV, MAXV, MAXV), mk(MINV, MINV, MINV, MINV));
        // half-LSB ties on both signs
        push_req(MODE_MUL, mk(1, 1, 1, 1), mk(8192, -8192, 8192, -8192));
        push_req(MODE_MUL, mk(0, ONE, 0, 0), mk(0, 0, ONE, 0));
        push_req(MODE_MUL, mk(-1, -1, -1, -1), mk(-1, -1, -1, -1));
        push_req(MODE_MUL, mk(MINV, MAXV, MINV, MAXV), mk(MAXV, MINV, MAXV, MINV));
        // rotate: b_w must be ignored
        push_req(MODE_ROT, mk(ONE, 0, 0, 0), mk(12345, 1000, -2000, 3000));
        push_req(MODE_ROT, mk(11585, 0, 0, 11585), mk(MINV, ONE, 0, 0));
        push_req(MODE_ROT, mk(MINV, MINV, MINV, MINV), mk(0, ONE, ONE, ONE));
        push_req(MODE_ROT, mk(MAXV, MAXV, MAXV, MAXV), mk(MAXV, MAXV, MAXV, MAXV));
        push_req(MODE_ROT, mk(MINV, MINV, MINV, MINV), mk(MINV, MINV, MINV, MINV));
        push_req(MODE_ROT, mk(0, MINV, 0, 0), mk(0, MAXV, MINV, MAXV));
        // non-unit a scales the vector, so the intermediate product saturates
        push_req(MODE_ROT, mk(ONE, ONE, 0, 0), mk(MAXV, 0, ONE, ONE));
        push_req(MODE_ROT, mk(0, 0, 0, 0), mk(MAXV, MAXV, MINV, MAXV));
        push_req(MODE_ROT, mk(MAXV, MINV, MAXV, MINV), mk(-1, MINV, MAXV, MINV));

        for (int i = 0; i < N_RAND; i++) begin
            quiet_send = (i >= 1200 && i < 1500);
            push_req(qmode_e'($urandom_range(1)), rnd_quat(), rnd_quat());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Covered %0d quaternion products and %0d vector rotations,", n_mul, n_rot);
        $display("with random gaps on both sides and a %0d-cycle output hold.", HOLD_LEN);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qmr_pkg.sv
rtl/qmr_prod_stage.sv
rtl/qmr_sum_stage.sv
rtl/quaternion_multiply_rotate_unit.sv
verif/qmr_tb_pkg.sv
verif/qmr_checker.sv
verif/tb.sv
